[design/ctf2d_pkg.sv]
// ctf2d_pkg: shared types and constants for the 2d contrast transfer function block
// no dependencies; used by the cordic cells, the rotator and the top level
package ctf2d_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_K1_SCALED     = 3'd0,
    REG_K2_SCALED     = 3'd1,
    REG_DEFOCUS_MAJOR = 3'd2,
    REG_DEFOCUS_MINOR = 3'd3,
    REG_ASTIG_ANGLE   = 3'd4,
    REG_PHASE_OFFSET  = 3'd5,
    REG_SINE_WEIGHT   = 3'd6,
    REG_COSINE_WEIGHT = 3'd7
  } cfg_reg_e;

  localparam int MAX_STEPS = 24;

  // vectoring datapath: x and y hold index << 24 with gain growth
  localparam int VEC_W = 36;
  // angle accumulators, binary turns plus headroom
  localparam int ANG_W = 34;
  // rotating datapath, q30
  localparam int ROT_W = 34;

  localparam logic signed [ROT_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [31:0] RAD24_TO_TURN_Q26 = 32'd2734261103;

  // atan(2^-k) in binary turns, 2^32 = 2 pi
  localparam logic [31:0] ATAN_TURNS [MAX_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

endpackage

[design/ctf2d_vec_cell.sv]
// ctf2d_vec_cell: one vectoring cordic iteration with its output register
// depends on ctf2d_pkg
module ctf2d_vec_cell #(
  parameter int K = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  vld_i,
  input  logic signed [ctf2d_pkg::VEC_W-1:0]    x_i,
  input  logic signed [ctf2d_pkg::VEC_W-1:0]    y_i,
  input  logic signed [ctf2d_pkg::ANG_W-1:0]    z_i,
  output logic                                  vld_o,
  output logic signed [ctf2d_pkg::VEC_W-1:0]    x_o,
  output logic signed [ctf2d_pkg::VEC_W-1:0]    y_o,
  output logic signed [ctf2d_pkg::ANG_W-1:0]    z_o
);

  logic signed [ctf2d_pkg::VEC_W-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [ctf2d_pkg::ANG_W-1:0] at, z_d, z_q;
  logic vld_q;

  assign dx = y_i >>> K;
  assign dy = x_i >>> K;
  assign at = signed'({{(ctf2d_pkg::ANG_W-32){1'b0}}, ctf2d_pkg::ATAN_TURNS[K]});

  always_comb begin
    if (y_i > 0) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + at;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign vld_o = vld_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;

endmodule

[design/ctf2d_rot_cell.sv]
// ctf2d_rot_cell: one rotating cordic iteration with its output register
// depends on ctf2d_pkg
module ctf2d_rot_cell #(
  parameter int K = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  vld_i,
  input  logic signed [ctf2d_pkg::ROT_W-1:0]    x_i,
  input  logic signed [ctf2d_pkg::ROT_W-1:0]    y_i,
  input  logic signed [ctf2d_pkg::ANG_W-1:0]    z_i,
  output logic                                  vld_o,
  output logic signed [ctf2d_pkg::ROT_W-1:0]    x_o,
  output logic signed [ctf2d_pkg::ROT_W-1:0]    y_o,
  output logic signed [ctf2d_pkg::ANG_W-1:0]    z_o
);

  logic signed [ctf2d_pkg::ROT_W-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [ctf2d_pkg::ANG_W-1:0] at, z_d, z_q;
  logic vld_q;

  assign dx = y_i >>> K;
  assign dy = x_i >>> K;
  assign at = signed'({{(ctf2d_pkg::ANG_W-32){1'b0}}, ctf2d_pkg::ATAN_TURNS[K]});

  always_comb begin
    if (!z_i[ctf2d_pkg::ANG_W-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - at;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign vld_o = vld_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;

endmodule

[design/ctf2d_rotator.sv]
// ctf2d_rotator: chain of rotating cordic cells giving cos and sin in q30
// depends on ctf2d_pkg and ctf2d_rot_cell; the cell chain is followed by a registered sign flip
module ctf2d_rotator #(
  parameter int STEPS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  vld_i,
  input  logic [31:0]                           angle_i,
  output logic                                  vld_o,
  output logic signed [ctf2d_pkg::ROT_W-1:0]    cos_o,
  output logic signed [ctf2d_pkg::ROT_W-1:0]    sin_o
);

  logic signed [ctf2d_pkg::ROT_W-1:0] rx [STEPS+1];
  logic signed [ctf2d_pkg::ROT_W-1:0] ry [STEPS+1];
  logic signed [ctf2d_pkg::ANG_W-1:0] rz [STEPS+1];
  logic                               rv [STEPS+1];
  logic                               flip_q [STEPS];
  logic                               flip_in;
  logic [31:0]                        ang;
  logic signed [ctf2d_pkg::ROT_W-1:0] cos_q, sin_q;
  logic                               vld_q;

  // left half plane: turn by pi, negate at the end
  assign flip_in = angle_i[31] ^ angle_i[30];
  assign ang     = {angle_i[31] ^ flip_in, angle_i[30:0]};

  assign rx[0] = ctf2d_pkg::CORDIC_GAIN_Q30;
  assign ry[0] = '0;
  assign rz[0] = signed'({{(ctf2d_pkg::ANG_W-32){ang[31]}}, ang});
  assign rv[0] = vld_i;

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    ctf2d_rot_cell #(.K(k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .vld_i  (rv[k]),
      .x_i    (rx[k]),
      .y_i    (ry[k]),
      .z_i    (rz[k]),
      .vld_o  (rv[k+1]),
      .x_o    (rx[k+1]),
      .y_o    (ry[k+1]),
      .z_o    (rz[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flip_q[0] <= flip_in;
      for (int k = 1; k < STEPS; k++) begin
        flip_q[k] <= flip_q[k-1];
      end
      cos_q <= flip_q[STEPS-1] ? -rx[STEPS] : rx[STEPS];
      sin_q <= flip_q[STEPS-1] ? -ry[STEPS] : ry[STEPS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= rv[STEPS];
    end
  end

  assign vld_o = vld_q;
  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

[design/contrast_transfer_function_2d_top.sv]
// contrast_transfer_function_2d_top: astigmatic ctf of one half-spectrum pixel per item
// depends on ctf2d_pkg, ctf2d_vec_cell and ctf2d_rotator
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata: col_freq[7:0], row_freq[15:8]
//  m_axis    out  m_axis_tvalid/tready       tdata: ctf_value[15:0]
//  cfg       in   cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// one item per cycle sustained while the skid slot is free; STEPS is CORDIC_STEPS
// capped at 24; items pass through the input stage, the vectoring chain,
// two rotating chains, the multiplier stages and the output register
// rst_ni clears all valid bits and loads register defaults; no clearing pass
// the whole pipeline stalls only when the two-entry output buffer is full; the stages
// read configuration registers live; user must write them only when idle; not enforced
module contrast_transfer_function_2d_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // col_freq [7:0], row_freq [15:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // ctf_value [15:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int STEPS = (CORDIC_STEPS > ctf2d_pkg::MAX_STEPS) ?
                         ctf2d_pkg::MAX_STEPS : CORDIC_STEPS;
  // r2 rides along the vectoring chain and the first rotator
  localparam int R2_LAT = 2 * STEPS + 1;
  localparam int DEF_W  = 30;
  localparam int PH_W   = 48;

  // ---------------- configuration registers ----------------
  logic [31:0] k1_q, k2_q;
  logic [16:0] dmaj_q, dmin_q;
  logic [15:0] astig_q, phase_q;
  logic [14:0] sw_q, cw_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q    <= '0;
      k2_q    <= '0;
      dmaj_q  <= '0;
      dmin_q  <= '0;
      astig_q <= '0;
      phase_q <= '0;
      sw_q    <= 15'd16384;
      cw_q    <= '0;
    end else if (cfg_valid_i) begin
      case (ctf2d_pkg::cfg_reg_e'(cfg_index_i))
        ctf2d_pkg::REG_K1_SCALED:     k1_q    <= cfg_data_i;
        ctf2d_pkg::REG_K2_SCALED:     k2_q    <= cfg_data_i;
        ctf2d_pkg::REG_DEFOCUS_MAJOR: dmaj_q  <= cfg_data_i[16:0];
        ctf2d_pkg::REG_DEFOCUS_MINOR: dmin_q  <= cfg_data_i[16:0];
        ctf2d_pkg::REG_ASTIG_ANGLE:   astig_q <= cfg_data_i[15:0];
        ctf2d_pkg::REG_PHASE_OFFSET:  phase_q <= cfg_data_i[15:0];
        ctf2d_pkg::REG_SINE_WEIGHT:   sw_q    <= cfg_data_i[14:0];
        ctf2d_pkg::REG_COSINE_WEIGHT: cw_q    <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic en;
  logic out_vld_q, skid_vld_q;
  logic [15:0] out_q, skid_q;

  // pipeline moves whenever the skid slot is free
  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  // ---------------- input stage: r2 and cordic start vector ----------------
  logic [7:0]                          col_i;
  logic signed [7:0]                   row_i;
  logic [15:0]                         isq, jsq_u;
  logic signed [15:0]                  jsq;
  logic                                vld0_q, org0_q;
  logic [16:0]                         r2_0_q;
  logic signed [ctf2d_pkg::VEC_W-1:0]  x0_q, y0_q;

  assign col_i = s_axis_tdata[7:0];
  assign row_i = signed'(s_axis_tdata[15:8]);
  assign isq   = {8'd0, col_i} * {8'd0, col_i};
  assign jsq   = {{8{row_i[7]}}, row_i} * {{8{row_i[7]}}, row_i};
  assign jsq_u = unsigned'(jsq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en) begin
      vld0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // columns beyond half size can push r2 past 16 bits
      r2_0_q <= {1'b0, isq} + {1'b0, jsq_u};
      org0_q <= (col_i == 8'd0) && (row_i == 8'sd0);
      x0_q   <= signed'({4'd0, col_i, 24'd0});
      y0_q   <= signed'({{4{row_i[7]}}, row_i, 24'd0});
    end
  end

  // ---------------- vectoring chain: phi = atan2(j, i) ----------------
  logic signed [ctf2d_pkg::VEC_W-1:0] vx [STEPS+1];
  logic signed [ctf2d_pkg::VEC_W-1:0] vy [STEPS+1];
  logic signed [ctf2d_pkg::ANG_W-1:0] vz [STEPS+1];
  logic                               vv [STEPS+1];

  assign vx[0] = x0_q;
  assign vy[0] = y0_q;
  assign vz[0] = '0;
  assign vv[0] = vld0_q;

  for (genvar k = 0; k < STEPS; k++) begin : g_vec
    ctf2d_vec_cell #(.K(k)) u_vec (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vv[k]),
      .x_i    (vx[k]),
      .y_i    (vy[k]),
      .z_i    (vz[k]),
      .vld_o  (vv[k+1]),
      .x_o    (vx[k+1]),
      .y_o    (vy[k+1]),
      .z_o    (vz[k+1])
    );
  end

  // origin flag and r2 ride alongside the cordic cells
  logic        org_q [STEPS];
  logic [16:0] r2_q  [R2_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      org_q[0] <= org0_q;
      for (int k = 1; k < STEPS; k++) begin
        org_q[k] <= org_q[k-1];
      end
      r2_q[0] <= r2_0_q;
      for (int k = 1; k < R2_LAT; k++) begin
        r2_q[k] <= r2_q[k-1];
      end
    end
  end

  // doubled angle relative to the astigmatism axis
  logic [31:0] phi, adiff, a2;
  assign phi   = org_q[STEPS-1] ? 32'd0 : vz[STEPS][31:0];
  assign adiff = phi - {astig_q, 16'd0};
  assign a2    = {adiff[30:0], 1'b0};

  // ---------------- first rotator: cos(2a) ----------------
  logic                               rota_vld;
  logic signed [ctf2d_pkg::ROT_W-1:0] c2, s2_unused;

  ctf2d_rotator #(.STEPS(STEPS)) u_rot_ang (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (vv[STEPS]),
    .angle_i (a2),
    .vld_o   (rota_vld),
    .cos_o   (c2),
    .sin_o   (s2_unused)
  );

  // ---------------- stage a: defocus in q8, k1*r2, r2*r2 ----------------
  logic [17:0]              dsum;
  logic signed [17:0]       ddiff;
  logic signed [51:0]       dprod, num;
  logic signed [51:0]       num_sh;
  logic [48:0]              k1r2;
  logic [33:0]              r2sq;
  logic [16:0]              r2a;
  logic                     vlda_q;
  logic signed [DEF_W-1:0]  def_q;
  logic [36:0]              a1_q;
  logic [25:0]              r4_q;

  assign r2a    = r2_q[R2_LAT-1];
  assign dsum   = {1'b0, dmaj_q} + {1'b0, dmin_q};
  assign ddiff  = signed'({1'b0, dmaj_q}) - signed'({1'b0, dmin_q});
  assign dprod  = ddiff * c2;
  assign num    = signed'({4'd0, dsum, 30'd0}) + dprod;
  assign num_sh = num >>> 23;
  assign k1r2   = {17'd0, k1_q} * {32'd0, r2a};
  assign r2sq   = {17'd0, r2a} * {17'd0, r2a};

  always_ff @(posedge clk_i) begin
    if (en) begin
      def_q <= -num_sh[DEF_W-1:0];
      a1_q  <= k1r2[48:12];
      r4_q  <= r2sq[33:8];
    end
  end

  // ---------------- stage b: partial products of term one, term two ----------------
  logic signed [49:0] plo_d, phi_d;
  logic signed [49:0] plo_q, phi_q;
  logic [57:0]        k2r4;
  logic [33:0]        t2_q;
  logic               vldb_q;

  assign plo_d = def_q * signed'({1'b0, a1_q[18:0]});
  assign phi_d = def_q * signed'({1'b0, a1_q[36:19]});
  assign k2r4  = {26'd0, k2_q} * {32'd0, r4_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
      t2_q  <= k2r4[57:24];
    end
  end

  // ---------------- stage c: phase in radians q24 ----------------
  logic signed [67:0]     t1_full, t1_sh;
  logic signed [PH_W-1:0] ph_q;
  logic                   vldc_q;

  assign t1_full = (68'(phi_q) <<< 19) + 68'(plo_q);
  assign t1_sh   = t1_full >>> 20;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph_q <= t1_sh[PH_W-1:0] + signed'({14'd0, t2_q});
    end
  end

  // ---------------- stage d: radians to turns, two partial products ----------------
  logic [55:0]        mlo_d, mlo_q;
  logic signed [56:0] mhi_d, mhi_q;
  logic signed [23:0] ph_hi;
  logic               vldd_q;

  assign ph_hi = ph_q[PH_W-1:24];
  assign mlo_d = {32'd0, ph_q[23:0]} * {24'd0, ctf2d_pkg::RAD24_TO_TURN_Q26};
  assign mhi_d = ph_hi * signed'({1'b0, ctf2d_pkg::RAD24_TO_TURN_Q26});

  always_ff @(posedge clk_i) begin
    if (en) begin
      mlo_q <= mlo_d;
      mhi_q <= mhi_d;
    end
  end

  // ---------------- stage e: turns modulo 2 pi, minus phase offset ----------------
  logic [57:0] tsum;
  logic [31:0] turns_q;
  logic        vlde_q;

  assign tsum = {2'd0, mlo_q} + {mhi_q[33:0], 24'd0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      turns_q <= tsum[57:26] - {phase_q, 16'd0};
    end
  end

  // ---------------- second rotator: cos and sin of the phase ----------------
  logic                               rotb_vld;
  logic signed [ctf2d_pkg::ROT_W-1:0] cp, sp;

  ctf2d_rotator #(.STEPS(STEPS)) u_rot_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (vlde_q),
    .angle_i (turns_q),
    .vld_o   (rotb_vld),
    .cos_o   (cp),
    .sin_o   (sp)
  );

  // ---------------- stage f: weighting products ----------------
  logic signed [49:0] pa_q, pb_q;
  logic               vldf_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q <= signed'({1'b0, sw_q}) * sp;
      pb_q <= signed'({1'b0, cw_q}) * cp;
    end
  end

  // ---------------- final: round, shift, saturate ----------------
  logic signed [50:0] acc, acc_sh;
  logic [15:0]        res;

  assign acc    = 51'(pb_q) - 51'(pa_q) + 51'sd536870912;
  assign acc_sh = acc >>> 30;

  always_comb begin
    if (acc_sh > 51'sd32767) begin
      res = 16'h7FFF;
    end else if (acc_sh < -51'sd32768) begin
      res = 16'h8000;
    end else begin
      res = acc_sh[15:0];
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlda_q <= 1'b0;
      vldb_q <= 1'b0;
      vldc_q <= 1'b0;
      vldd_q <= 1'b0;
      vlde_q <= 1'b0;
      vldf_q <= 1'b0;
    end else if (en) begin
      vlda_q <= rota_vld;
      vldb_q <= vlda_q;
      vldc_q <= vldb_q;
      vldd_q <= vldc_q;
      vlde_q <= vldd_q;
      vldf_q <= rotb_vld;
    end
  end

  // ---------------- output register with skid slot ----------------
  logic take, new_item;

  assign take     = out_vld_q && m_axis_tready;
  assign new_item = en && vldf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (out_vld_q && !take) begin
      skid_vld_q <= new_item;
    end else begin
      out_vld_q <= new_item;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (out_vld_q && !take) begin
      if (new_item) begin
        skid_q <= res;
      end
    end else if (new_item) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTH
  // the skid slot only ever holds an item behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid slot holds an item while output is empty");

  // the skid slot fills only when the output was stalled
  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !m_axis_tready))
    else $error("skid slot filled without an output stall");

  // a taken output with a full skid slot keeps the output valid and empties the skid slot
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && m_axis_tready |=> out_vld_q && !skid_vld_q)
    else $error("skid slot did not drain into the output");
`endif

endmodule
